FILE: hw/rtl/stack_frame_allocator_core_macros.svh
// Assertion helpers for the allocator core.
`ifndef STACK_FRAME_ALLOCATOR_CORE_MACROS_SVH
`define STACK_FRAME_ALLOCATOR_CORE_MACROS_SVH

// Check a same-cycle implication, disabled in reset.
`define SFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle, disabled in reset.
`define SFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sfa_pkg.sv
package sfa_pkg;

  localparam int OFS_W        = 24;
  localparam int LEVEL_W      = 7;
  localparam int OPC_W        = 3;
  localparam int STAT_W       = 3;
  localparam int MAX_FRAMES_D = 64;
  localparam int LINK_BYTES_D = 8;

  typedef enum logic [OPC_W-1:0] {
    OP_ALLOC     = 3'd0,
    OP_FREE_ADDR = 3'd1,
    OP_FREE_SIZE = 3'd2,
    OP_FREE_ALL  = 3'd3,
    OP_BEGIN     = 3'd4,
    OP_END       = 3'd5,
    OP_UNROLL    = 3'd6
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOSPACE   = 3'd1,
    ST_BADADDR   = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UNROLL,
    S_REFILL
  } state_t;

endpackage

FILE: hw/rtl/sfa_base_mem.sv
module sfa_base_mem
  import sfa_pkg::*;
#(
  parameter int DEPTH = MAX_FRAMES_D,
  parameter int WIDTH = OFS_W
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/stack_frame_allocator_core.sv
// LIFO byte allocator over a region of cfg_capacity_bytes bytes, answering with
// offsets. Every accepted command yields exactly one result, shown on the out_
// ports for one cycle with out_valid; the receiver cannot stall, so take each
// result when out_valid is high. Most commands show their result in the cycle
// right after the start transfer. End frame and unroll that pop a frame hold
// busy through the refill state while the saved frame base below the new top
// is read back from the frame memory (registered read port), unless they end at
// level zero. Unroll pops one frame per cycle and shows its result in the cycle
// after the last pop. The capacity register is written through cfg_valid/
// cfg_ready; the user must write it only while no command is in flight, as the
// block itself does not enforce it.
`include "stack_frame_allocator_core_macros.svh"

module stack_frame_allocator_core
  import sfa_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_D,
  parameter int LINK_BYTES = LINK_BYTES_D
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OPC_W-1:0]   in_opcode,
  input  logic [OFS_W-1:0]   in_size_bytes,
  input  logic [OFS_W-1:0]   in_address,
  input  logic [LEVEL_W-1:0] in_target_level,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [OFS_W-1:0]   out_offset,
  output logic [OFS_W-1:0]   out_used_bytes,
  output logic [LEVEL_W-1:0] out_frame_level,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [OFS_W-1:0]   cfg_capacity_bytes
);

  localparam int IDXW = $clog2(MAX_FRAMES);
  localparam int LVLW = $clog2(MAX_FRAMES + 1);
  localparam int CMPW = (LVLW > LEVEL_W) ? LVLW : LEVEL_W;
  localparam logic [OFS_W-1:0] LINK = OFS_W'(LINK_BYTES);
  localparam logic [LVLW-1:0] LVL_MAX = LVLW'(MAX_FRAMES);

  state_t             state_r, state_nxt;
  logic [OFS_W-1:0]   top_r, top_nxt;
  logic [OFS_W-1:0]   base_r, base_nxt;
  logic [OFS_W-1:0]   below_r, below_nxt;
  logic [LVLW-1:0]    level_r, level_nxt;
  logic [OFS_W-1:0]   cap_r;
  logic [LEVEL_W-1:0] tgt_r, tgt_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [OFS_W-1:0]   out_offset_r, out_offset_nxt;
  logic [OFS_W-1:0]   out_used_r;
  logic [LVLW-1:0]    out_level_r;

  logic               wr_en;
  logic [IDXW-1:0]    wr_addr;
  logic               rd_en;
  logic [IDXW-1:0]    rd_addr;
  logic [OFS_W-1:0]   rd_data;

  logic [OFS_W:0]     alloc_sum;
  logic [OFS_W:0]     link_sum;
  logic [OFS_W-1:0]   pop_top;
  logic [OFS_W-1:0]   pop_base;
  logic [LVLW-1:0]    pop_level;
  logic [LVLW-1:0]    level_m2;
  logic [CMPW-1:0]    lvl_ext;
  logic [CMPW-1:0]    dec_ext;
  logic [CMPW-1:0]    tgt_ext;

  sfa_base_mem #(
    .DEPTH (MAX_FRAMES),
    .WIDTH (OFS_W)
  ) u_base_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (base_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign alloc_sum = {1'b0, top_r} + {1'b0, in_size_bytes};
  assign link_sum  = {1'b0, top_r} + {1'b0, LINK};
  assign pop_top   = (base_r >= LINK) ? (base_r - LINK) : '0;
  assign pop_base  = (state_r == S_UNROLL) ? rd_data : below_r;
  assign pop_level = level_r - LVLW'(1);
  assign level_m2  = level_r - LVLW'(2);
  assign lvl_ext   = CMPW'(level_r);
  assign dec_ext   = CMPW'(pop_level);
  assign tgt_ext   = (state_r == S_IDLE) ? CMPW'(in_target_level) : CMPW'(tgt_r);
  assign wr_addr   = level_r[IDXW-1:0];
  assign rd_addr   = level_m2[IDXW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      base_r      <= '0;
      level_r     <= '0;
      cap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      base_r      <= base_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity_bytes;
      end
    end
  end

  always_ff @(posedge clk) begin
    below_r      <= below_nxt;
    tgt_r        <= tgt_nxt;
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
    out_used_r   <= top_nxt;
    out_level_r  <= level_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    base_nxt       = base_r;
    below_nxt      = below_r;
    level_nxt      = level_r;
    tgt_nxt        = tgt_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_offset_nxt = '0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          tgt_nxt       = in_target_level;
          case (opcode_t'(in_opcode))
            OP_ALLOC: begin
              if (alloc_sum > {1'b0, cap_r}) begin
                out_status_nxt = ST_NOSPACE;
              end else begin
                out_offset_nxt = top_r;
                top_nxt        = alloc_sum[OFS_W-1:0];
              end
            end
            OP_FREE_ADDR: begin
              if (in_address >= base_r && in_address < top_r) begin
                top_nxt = in_address;
              end else begin
                out_status_nxt = ST_BADADDR;
              end
            end
            OP_FREE_SIZE: begin
              if (in_size_bytes > (top_r - base_r)) begin
                top_nxt = base_r;
              end else begin
                top_nxt = top_r - in_size_bytes;
              end
            end
            OP_FREE_ALL: begin
              top_nxt = base_r;
            end
            OP_BEGIN: begin
              if (level_r >= LVL_MAX) begin
                out_status_nxt = ST_OVERFLOW;
              end else if (link_sum >= {1'b0, cap_r}) begin
                out_status_nxt = ST_NOSPACE;
              end else begin
                wr_en     = 1'b1;
                below_nxt = base_r;
                top_nxt   = link_sum[OFS_W-1:0];
                base_nxt  = link_sum[OFS_W-1:0];
                level_nxt = level_r + LVLW'(1);
              end
            end
            OP_END: begin
              if (level_r == '0) begin
                out_status_nxt = ST_UNDERFLOW;
              end else begin
                top_nxt   = pop_top;
                base_nxt  = pop_base;
                level_nxt = pop_level;
                rd_en     = (level_r >= LVLW'(2));
                state_nxt = (pop_level != '0) ? S_REFILL : S_IDLE;
              end
            end
            OP_UNROLL: begin
              if (lvl_ext <= tgt_ext) begin
                out_status_nxt = ST_UNDERFLOW;
              end else begin
                top_nxt   = pop_top;
                base_nxt  = pop_base;
                level_nxt = pop_level;
                rd_en     = (level_r >= LVLW'(2));
                if (dec_ext == tgt_ext) begin
                  state_nxt = (pop_level != '0) ? S_REFILL : S_IDLE;
                end else begin
                  out_valid_nxt = 1'b0;
                  state_nxt     = S_UNROLL;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_UNROLL: begin
        top_nxt   = pop_top;
        base_nxt  = pop_base;
        level_nxt = pop_level;
        rd_en     = (level_r >= LVLW'(2));
        if (dec_ext == tgt_ext) begin
          out_valid_nxt = 1'b1;
          state_nxt     = (pop_level != '0) ? S_REFILL : S_IDLE;
        end
      end
      S_REFILL: begin
        below_nxt = rd_data;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_offset      = out_offset_r;
  assign out_used_bytes  = out_used_r;
  assign out_frame_level = LEVEL_W'(out_level_r);

  `SFA_ASSERT_NOW(a_wr_only_idle, wr_en, state_r == S_IDLE, "frame push outside idle")
  `SFA_ASSERT_NOW(a_top_above_base, 1'b1, top_r >= base_r, "top below frame base")
  `SFA_ASSERT_NOW(a_level_bound, 1'b1, level_r <= LVL_MAX, "frame level beyond depth")
  `SFA_ASSERT_NEXT(a_refill_done, state_r == S_REFILL, state_r == S_IDLE, "refill not one cycle")
  `SFA_ASSERT_NEXT(a_result_follows, start && !busy && in_opcode != OP_UNROLL, out_valid_r, "command without result")

endmodule
